[rtl/xkb64_pkg.sv]
// Package with payload types, register indexes and the Base64 alphabet for the XOR/Base64 encoder.
`timescale 1ns / 1ps

package xkb64_pkg;

  // Largest key the block supports
  localparam int MAX_KEY_BYTES_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  localparam int KEY_LEN_W = 5;
  localparam logic [7:0] PAD_CHAR = 8'h3d;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       end_of_message;
  } enc_in_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       final_char;
  } enc_out_t;

  // Map a 6-bit value onto the standard Base64 alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

[rtl/xor_key_base64_encoder_unit.sv]
// Top level of the repeating-key XOR and Base64 encoder.
`timescale 1ns / 1ps

// Takes one plaintext byte per request, XORs it with the key byte at its position in
// the message and packs every three bytes into four Base64 characters, one character
// per output request; the last byte of a message flushes a partial group with '='
// padding, and a key length of zero drops everything. Each finished group holds the
// output register until its four characters have gone out one at a time through the
// single character output port. A byte that completes a group is held off only while
// the previous group still has characters to send; all other bytes pass at once.
// Configuration writes are always ready and take effect in the next cycle.
module xor_key_base64_encoder_unit #(
  parameter int MAX_KEY_BYTES = xkb64_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  xkb64_pkg::enc_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output xkb64_pkg::enc_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [63:0]                 cfg_data
);
  import xkb64_pkg::*;

  localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  // Configuration registers
  logic [63:0]          key_low;
  logic [63:0]          key_high;
  logic [KEY_LEN_W-1:0] key_length;

  // Message state
  logic [15:0]          pending_bytes;
  logic [1:0]           group_fill;
  logic [POS_W-1:0]     key_position;

  // Output group register
  logic [7:0]           group_chars [4];
  logic                 group_last;
  logic                 group_valid;
  logic [1:0]           char_idx;

  logic [127:0]         key_all;
  logic [KEY_LEN_W-1:0] len_eff;
  logic                 key_on;
  logic [KEY_LEN_W-1:0] pos_cur;
  logic [KEY_LEN_W-1:0] pos_inc;
  logic [POS_W-1:0]     pos_next;
  logic [7:0]           key_byte;
  logic [7:0]           xbyte;
  logic [1:0]           fill_sat;
  logic                 completes;
  logic [7:0]           b0, b1, b2;
  logic [7:0]           ch_next [4];
  logic                 in_fire;
  logic                 out_fire;
  logic                 drain;

  assign cfg_ready = 1'b1;

  // Clamp the key length and pick the key byte for this position
  always_comb begin
    key_all  = {key_high, key_low};
    len_eff  = (key_length > MAX_LEN) ? MAX_LEN : key_length;
    key_on   = (len_eff != '0);
    pos_cur  = (KEY_LEN_W'(key_position) >= len_eff) ? '0 : KEY_LEN_W'(key_position);
    pos_inc  = pos_cur + KEY_LEN_W'(1);
    pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
    key_byte = key_all[{pos_cur[3:0], 3'b000} +: 8];
    xbyte    = in_data.plain_byte ^ key_byte;
    fill_sat = (group_fill == 2'd3) ? 2'd2 : group_fill;
    completes = key_on && ((fill_sat == 2'd2) || in_data.end_of_message);
  end

  // Assemble the group bytes and its four characters
  always_comb begin
    case (fill_sat)
      2'd0: begin
        b0 = xbyte;
        b1 = 8'h00;
        b2 = 8'h00;
      end
      2'd1: begin
        b0 = pending_bytes[7:0];
        b1 = xbyte;
        b2 = 8'h00;
      end
      default: begin
        b0 = pending_bytes[7:0];
        b1 = pending_bytes[15:8];
        b2 = xbyte;
      end
    endcase
    ch_next[0] = b64_char(b0[7:2]);
    ch_next[1] = b64_char({b0[1:0], b1[7:4]});
    ch_next[2] = (fill_sat == 2'd0) ? PAD_CHAR : b64_char({b1[3:0], b2[7:6]});
    ch_next[3] = (fill_sat == 2'd2) ? b64_char(b2[5:0]) : PAD_CHAR;
  end

  // Handshakes: hold a completing byte while the previous group is still sending
  assign out_fire  = group_valid && !out_stall;
  assign drain     = out_fire && (char_idx == 2'd3);
  assign in_stall  = group_valid && !drain && completes;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = group_valid;

  always_comb begin
    out_data.code_char  = group_chars[char_idx];
    out_data.final_char = group_last && (char_idx == 2'd3);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      key_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low    <= cfg_data;
        REG_KEY_HIGH: key_high   <= cfg_data;
        REG_KEY_LEN:  key_length <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance key position and group fill on each accepted byte while a key length is set
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      group_fill    <= '0;
      key_position  <= '0;
    end else if (in_fire) begin
      if (!key_on) begin
        if (in_data.end_of_message) begin
          pending_bytes <= '0;
          group_fill    <= '0;
          key_position  <= '0;
        end
      end else if (completes) begin
        pending_bytes <= '0;
        group_fill    <= '0;
        key_position  <= in_data.end_of_message ? '0 : pos_next;
      end else begin
        key_position <= pos_next;
        group_fill   <= fill_sat + 2'd1;
        if (fill_sat == 2'd0) begin
          pending_bytes[7:0] <= xbyte;
        end else begin
          pending_bytes[15:8] <= xbyte;
        end
      end
    end
  end

  // Load a finished group and step through its characters
  always_ff @(posedge clk) begin
    if (rst) begin
      group_valid <= 1'b0;
      char_idx    <= '0;
    end else if (in_fire && completes) begin
      group_valid <= 1'b1;
      char_idx    <= '0;
    end else if (out_fire) begin
      if (char_idx == 2'd3) begin
        group_valid <= 1'b0;
      end
      char_idx <= char_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && completes) begin
      group_chars <= ch_next;
      group_last  <= in_data.end_of_message;
    end
  end

  // Checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    group_fill != 2'd3) else $error("group fill out of range");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (group_valid && char_idx != 2'd3) || (group_valid && out_stall))
    else $error("input held with no group pending");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (in_fire && completes) |=> (group_valid && char_idx == 2'd0))
    else $error("completed group not loaded");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.final_char) |-> (char_idx == 2'd3 && group_last))
    else $error("final flag away from last character");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (drain && !(in_fire && completes)) |=> !group_valid)
    else $error("group still valid after last character");

endmodule
